/* rtl/assert_macros.svh */
// Assertion macros shared by the sRGB to L*a*b* RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds -> prop holds in the same cycle
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond holds -> prop holds in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/s2lab_pkg.sv */
// Package for the sRGB to CIE L*a*b* pixel core: word types, fixed-point
// constants, the inverse-gamma table and small arithmetic helpers. No dependencies.
package s2lab_pkg;

    localparam int FRAC_BITS = 8;
    localparam int Q         = 30;
    localparam int OUT_SHIFT = Q - FRAC_BITS;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef struct packed {
        logic [14:0]        lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } lab_t;

    // white-scaled tristimulus, Q30
    typedef struct packed {
        logic [30:0] x;
        logic [30:0] y;
        logic [30:0] z;
    } xyz_t;

    // Lab function result with its argument, Q30
    typedef struct packed {
        logic [30:0] f;
        logic [30:0] t;
        logic        above;
    } labf_t;

    typedef logic [255:0][30:0] lin_table_t;
    typedef logic [29:0] mtx_t [3][3];

    localparam mtx_t MTX = '{
        '{30'd412390799, 30'd357584339, 30'd180480788},
        '{30'd212639006, 30'd715168679, 30'd72192315},
        '{30'd19330819,  30'd119194780, 30'd950532152}
    };
    localparam logic [30:0] INV_XN = 31'd1052126558;
    localparam logic [30:0] INV_ZN = 31'd918481126;

    localparam logic [63:0] BILLION      = 64'd1000000000;
    localparam logic [63:0] HALF_BILLION = 64'd500000000;
    localparam logic [63:0] BILLION_X3   = 64'd3000000000;
    localparam logic [63:0] KILO         = 64'd1000;
    localparam logic [63:0] TEN          = 64'd10;

    // reciprocals for divide-by-constant, quotient estimate low by at most 2
    localparam logic [63:0] R_BILLION = (64'd1 << 61) / BILLION;
    localparam logic [63:0] R_KILO    = (64'd1 << 34) / KILO;
    localparam logic [63:0] R_TEN     = (64'd1 << 26) / TEN;

    localparam logic [63:0] THR64  = (64'd8856 << Q) / 64'd1000000;
    localparam logic [30:0] THR    = THR64[30:0];
    localparam logic [63:0] LAB_K64 =
        (64'd13793103448 * 64'd1073741824 + 64'd50000000000) / 64'd100000000000;
    localparam logic [30:0] LAB_K  = LAB_K64[30:0];

    localparam int LMAX_INT = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);
    localparam logic signed [47:0] LMAX = 48'(LMAX_INT);
    localparam logic [47:0] OUT_HALF = 48'd1 << (OUT_SHIFT - 1);

    function automatic logic [63:0] qpow5(input logic [63:0] r);
        logic [63:0] p;
        p = r;
        for (int i = 1; i < 5; i++) begin
            p = (p * r) >> Q;
        end
        return p;
    endfunction

    function automatic logic [30:0] lin_entry(input logic [63:0] c);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (c * 64'd100000 <= 64'd1031475) begin
            return 31'((((c << Q) * 64'd10) + 64'd16473) / 64'd32946);
        end
        u  = (((64'd1000 * c + 64'd14025) << Q) + 64'd134512) / 64'd269025;
        u2 = (u * u + (64'd1 << (Q - 1))) >> Q;
        lo = 64'd0;
        hi = 64'd1 << Q;
        for (int k = 0; k < 40; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (qpow5(mid) <= u2) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return 31'((u2 * lo + (64'd1 << (Q - 1))) >> Q);
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = lin_entry(64'(c));
        end
        return tab;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

    // finish a quotient estimate from its remainder (estimate low by 0..2)
    function automatic logic [31:0] fix_quot(input logic [31:0] q0, input logic [63:0] rem,
                                             input logic [63:0] d);
        logic [31:0] q;
        priority if (rem >= (d << 1)) begin
            q = q0 + 32'd2;
        end else if (rem >= d) begin
            q = q0 + 32'd1;
        end else begin
            q = q0;
        end
        return q;
    endfunction

    // Q30 to FRAC_BITS, ties away from zero
    function automatic logic signed [47:0] to_out(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] m;
        mag = v[47] ? 48'(-v) : 48'(v);
        m   = (mag + OUT_HALF) >> OUT_SHIFT;
        return v[47] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        priority if (v > 48'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [14:0] clamp_l(input logic signed [47:0] v);
        logic [14:0] r;
        priority if (v < 48'sd0) begin
            r = 15'd0;
        end else if (v > LMAX) begin
            r = LMAX[14:0];
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

endpackage

/* rtl/s2lab_xyz.sv */
// Linearization table, sRGB to XYZ matrix and white-point scaling, 10 stages.
// Uses s2lab_pkg and assert_macros.svh.
`include "assert_macros.svh"

module s2lab_xyz (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  s2lab_pkg::pix_t    pix,
    output logic               out_valid,
    output s2lab_pkg::xyz_t    xyz
);

    logic [9:0]  v_reg;
    logic [30:0] lin_reg [3];
    logic [63:0] prod_reg [3][3];
    logic [63:0] s3_n_reg [3];
    logic [31:0] s4_q_reg [3];
    logic [63:0] s4_n_reg [3];
    logic [31:0] s5_q_reg [3];
    logic [63:0] s5_n_reg [3];
    logic [63:0] s5_m_reg [3];
    logic [30:0] s6_xyz_reg [3];
    // lanes below: 0 is X, 1 is Z; Y rides along
    logic [63:0] s7_n_reg [2];
    logic [31:0] s8_q_reg [2];
    logic [63:0] s8_n_reg [2];
    logic [31:0] s9_q_reg [2];
    logic [63:0] s9_n_reg [2];
    logic [63:0] s9_m_reg [2];
    logic [30:0] s10_t_reg [2];
    logic [30:0] y7_reg, y8_reg, y9_reg, y10_reg;
    logic [63:0] rem5 [3];
    logic [63:0] rem9 [2];
    logic        rem5_ok;

    always_comb
    begin
        rem5_ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            rem5[i] = s5_n_reg[i] - s5_m_reg[i];
            if (rem5[i] >= s2lab_pkg::BILLION_X3) begin
                rem5_ok = 1'b0;
            end
        end
        for (int i = 0; i < 2; i++) begin
            rem9[i] = s9_n_reg[i] - s9_m_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            lin_reg[0] <= s2lab_pkg::LIN_TABLE[pix.red];
            lin_reg[1] <= s2lab_pkg::LIN_TABLE[pix.green];
            lin_reg[2] <= s2lab_pkg::LIN_TABLE[pix.blue];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= 64'(s2lab_pkg::MTX[i][j]) * 64'(lin_reg[j]);
                end
                s3_n_reg[i] <= prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2]
                               + s2lab_pkg::HALF_BILLION;
                s4_q_reg[i] <= 32'((64'(s3_n_reg[i][60:29]) * s2lab_pkg::R_BILLION) >> 32);
                s4_n_reg[i] <= s3_n_reg[i];
                s5_q_reg[i] <= s4_q_reg[i];
                s5_n_reg[i] <= s4_n_reg[i];
                s5_m_reg[i] <= 64'(s4_q_reg[i]) * s2lab_pkg::BILLION;
                s6_xyz_reg[i] <= 31'(s2lab_pkg::fix_quot(s5_q_reg[i], rem5[i],
                                                         s2lab_pkg::BILLION));
            end
            s7_n_reg[0] <= 64'(s6_xyz_reg[0]) * 64'(s2lab_pkg::INV_XN)
                           + s2lab_pkg::HALF_BILLION;
            s7_n_reg[1] <= 64'(s6_xyz_reg[2]) * 64'(s2lab_pkg::INV_ZN)
                           + s2lab_pkg::HALF_BILLION;
            y7_reg  <= s6_xyz_reg[1];
            y8_reg  <= y7_reg;
            y9_reg  <= y8_reg;
            y10_reg <= y9_reg;
            for (int i = 0; i < 2; i++) begin
                s8_q_reg[i] <= 32'((64'(s7_n_reg[i][60:29]) * s2lab_pkg::R_BILLION) >> 32);
                s8_n_reg[i] <= s7_n_reg[i];
                s9_q_reg[i] <= s8_q_reg[i];
                s9_n_reg[i] <= s8_n_reg[i];
                s9_m_reg[i] <= 64'(s8_q_reg[i]) * s2lab_pkg::BILLION;
                s10_t_reg[i] <= 31'(s2lab_pkg::fix_quot(s9_q_reg[i], rem9[i],
                                                        s2lab_pkg::BILLION));
            end
        end
    end

    assign out_valid = v_reg[9];
    assign xyz.x     = s10_t_reg[0];
    assign xyz.y     = y10_reg;
    assign xyz.z     = s10_t_reg[1];

    `ASSERT_IMPLY(billion_rem_ok, v_reg[4], rem5_ok, "divide by 1e9 estimate out of range")

endmodule

/* rtl/s2lab_cbrt.sv */
// Lab function of one channel: bitwise cube-root pipeline (two stages a bit)
// with the linear branch alongside, 65 stages. Uses s2lab_pkg, assert_macros.svh.
`include "assert_macros.svh"

module s2lab_cbrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [30:0]        t,
    output logic               out_valid,
    output s2lab_pkg::labf_t   res
);

    localparam int BITS = 31;

    logic        p1_v_reg, p2_v_reg, p3_v_reg;
    logic [33:0] p1_m_reg, p2_m_reg;
    logic [30:0] p1_base_reg, p2_base_reg;
    logic [30:0] p1_t_reg, p2_t_reg, p3_t_reg;
    logic [24:0] p2_q_reg;
    logic [30:0] p3_low_reg;
    logic [63:0] p2_rem;

    logic        a_v_reg [BITS];
    logic [30:0] a_c_reg [BITS];
    logic [30:0] a_r_reg [BITS];
    logic [30:0] a_t_reg [BITS];
    logic [30:0] a_l_reg [BITS];
    logic [31:0] a_sq_reg [BITS];
    logic        b_v_reg [BITS];
    logic [30:0] b_r_reg [BITS];
    logic [30:0] b_t_reg [BITS];
    logic [30:0] b_l_reg [BITS];

    logic        src_v [BITS];
    logic [30:0] src_r [BITS];
    logic [30:0] src_t [BITS];
    logic [30:0] src_l [BITS];
    logic [30:0] cand  [BITS];
    logic [63:0] cube  [BITS];

    assign p2_rem = 64'(p2_m_reg) - 64'(p2_q_reg) * s2lab_pkg::KILO;

    always_comb
    begin
        for (int i = 0; i < BITS; i++) begin
            if (i == 0) begin
                src_v[i] = p3_v_reg;
                src_r[i] = '0;
                src_t[i] = p3_t_reg;
                src_l[i] = p3_low_reg;
            end else begin
                src_v[i] = b_v_reg[i - 1];
                src_r[i] = b_r_reg[i - 1];
                src_t[i] = b_t_reg[i - 1];
                src_l[i] = b_l_reg[i - 1];
            end
            cand[i] = src_r[i] | (31'd1 << (BITS - 1 - i));
            cube[i] = (64'(a_sq_reg[i]) * 64'(a_c_reg[i])) >> s2lab_pkg::Q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            for (int i = 0; i < BITS; i++) begin
                a_v_reg[i] <= 1'b0;
                b_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            p1_v_reg <= in_valid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            for (int i = 0; i < BITS; i++) begin
                a_v_reg[i] <= src_v[i];
                b_v_reg[i] <= a_v_reg[i];
            end
        end
    end

    // linear branch: 7t + (787t + 500) / 1000 + 16/116, only t below 2^24 matters
    always_ff @(posedge clk)
    begin
        if (en) begin
            p1_m_reg    <= 34'(34'(t[23:0]) * 34'd787 + 34'd500);
            p1_base_reg <= 31'(31'(t[23:0]) * 31'd7);
            p1_t_reg    <= t;
            p2_q_reg    <= 25'((64'(p1_m_reg[33:9]) * s2lab_pkg::R_KILO) >> 25);
            p2_m_reg    <= p1_m_reg;
            p2_base_reg <= p1_base_reg;
            p2_t_reg    <= p1_t_reg;
            p3_low_reg  <= p2_base_reg + s2lab_pkg::LAB_K
                           + 31'(s2lab_pkg::fix_quot(32'(p2_q_reg), p2_rem,
                                                     s2lab_pkg::KILO));
            p3_t_reg    <= p2_t_reg;
            for (int i = 0; i < BITS; i++) begin
                a_c_reg[i]  <= cand[i];
                a_r_reg[i]  <= src_r[i];
                a_t_reg[i]  <= src_t[i];
                a_l_reg[i]  <= src_l[i];
                a_sq_reg[i] <= 32'((62'(cand[i]) * 62'(cand[i])) >> s2lab_pkg::Q);
                b_r_reg[i]  <= (cube[i] <= 64'(a_t_reg[i])) ? a_c_reg[i] : a_r_reg[i];
                b_t_reg[i]  <= a_t_reg[i];
                b_l_reg[i]  <= a_l_reg[i];
            end
        end
    end

    assign out_valid = b_v_reg[BITS - 1];
    assign res.above = b_t_reg[BITS - 1] > s2lab_pkg::THR;
    assign res.t     = b_t_reg[BITS - 1];
    assign res.f     = res.above ? b_r_reg[BITS - 1] : b_l_reg[BITS - 1];

    `ASSERT_IMPLY(kilo_rem_ok, p2_v_reg, p2_rem < 64'd3000, "divide by 1000 estimate out of range")

endmodule

/* rtl/s2lab_lab.sv */
// Final L*, a*, b* arithmetic: differences, rounding to FRAC_BITS, saturation
// and the linear lightness branch, 4 stages. Uses s2lab_pkg.
module s2lab_lab (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  s2lab_pkg::labf_t   fx,
    input  s2lab_pkg::labf_t   fy,
    input  s2lab_pkg::labf_t   fz,
    output logic               out_valid,
    output s2lab_pkg::lab_t    lab
);

    logic [3:0]         v_reg;
    logic signed [47:0] fx_s, fy_s, fz_s;
    logic signed [47:0] a1_reg, b1_reg, lh1_reg;
    logic [25:0]        lym1_reg, lym2_reg;
    logic [33:0]        lyb1_reg, lyb2_reg;
    logic               above1_reg, above2_reg, above3_reg;
    logic signed [47:0] a2_reg, b2_reg, lh2_reg, lh3_reg;
    logic [22:0]        lq2_reg;
    logic signed [15:0] a3_reg, b3_reg;
    logic [47:0]        ly3_reg;
    logic [63:0]        ly_rem;
    s2lab_pkg::lab_t    lab_reg;

    assign fx_s   = $signed(48'(fx.f));
    assign fy_s   = $signed(48'(fy.f));
    assign fz_s   = $signed(48'(fz.f));
    assign ly_rem = 64'(lym2_reg) - 64'(lq2_reg) * s2lab_pkg::TEN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a1_reg     <= (fx_s - fy_s) * 48'sd500;
            b1_reg     <= (fy_s - fz_s) * 48'sd200;
            lh1_reg    <= fy_s * 48'sd116 - (48'sd16 <<< s2lab_pkg::Q);
            // 903.3 y = 903 y + (3y + 5) / 10 with rounding
            lym1_reg   <= 26'(26'(fy.t[23:0]) * 26'd3 + 26'd5);
            lyb1_reg   <= 34'(34'(fy.t[23:0]) * 34'd903);
            above1_reg <= fy.above;

            a2_reg     <= s2lab_pkg::to_out(a1_reg);
            b2_reg     <= s2lab_pkg::to_out(b1_reg);
            lh2_reg    <= s2lab_pkg::to_out(lh1_reg);
            lq2_reg    <= 23'((64'(lym1_reg[25:3]) * s2lab_pkg::R_TEN) >> 23);
            lym2_reg   <= lym1_reg;
            lyb2_reg   <= lyb1_reg;
            above2_reg <= above1_reg;

            a3_reg     <= s2lab_pkg::sat16(a2_reg);
            b3_reg     <= s2lab_pkg::sat16(b2_reg);
            lh3_reg    <= lh2_reg;
            ly3_reg    <= 48'(lyb2_reg)
                          + 48'(s2lab_pkg::fix_quot(32'(lq2_reg), ly_rem, s2lab_pkg::TEN));
            above3_reg <= above2_reg;

            lab_reg.lightness   <= above3_reg ? s2lab_pkg::clamp_l(lh3_reg)
                                   : s2lab_pkg::clamp_l(s2lab_pkg::to_out($signed(ly3_reg)));
            lab_reg.green_red   <= a3_reg;
            lab_reg.blue_yellow <= b3_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign lab       = lab_reg;

endmodule

/* rtl/srgb_to_cielab_pixel_core.sv */
// sRGB to CIE L*a*b* (D65) pixel core, top level.
// Uses s2lab_pkg, s2lab_xyz, s2lab_cbrt, s2lab_lab and assert_macros.svh.
//
// Input channel pix/pix_valid/pix_stall carries one 8-bit sRGB pixel a word;
// output channel lab/lab_valid/lab_stall carries L*, a*, b* with FRAC_BITS
// fraction bits. A word moves when valid is high and stall is low.
// Throughput: one pixel per clock while lab_stall stays low.
// Pipeline: 80 register stages (10 matrix and white-point, 65 of the bitwise
// cube root, 4 output, 1 output register); lab_valid rises when the pixel's
// word reaches that output register.
// The cube root resolves one result bit per two stages over 31 bits; that
// chain sets the latency.
// Reset clears every valid bit; the pipeline comes out empty and needs no
// warm-up.
// When lab_stall holds a word, the word behind it drops into a one-word skid
// register; the pipeline and pix_stall hold only while that skid is full, and
// nothing is lost or repeated.
`include "assert_macros.svh"

module srgb_to_cielab_pixel_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  s2lab_pkg::pix_t   pix,
    output logic              lab_valid,
    input  logic              lab_stall,
    output s2lab_pkg::lab_t   lab
);

    logic              en;
    logic              xyz_valid;
    s2lab_pkg::xyz_t   xyz;
    logic              fx_valid, fy_valid, fz_valid;
    s2lab_pkg::labf_t  fx, fy, fz;
    logic              pipe_valid;
    s2lab_pkg::lab_t   pipe_lab;

    logic              lab_valid_reg, lab_valid_next;
    s2lab_pkg::lab_t   lab_reg, lab_next;
    logic              skid_valid_reg, skid_valid_next;
    s2lab_pkg::lab_t   skid_reg, skid_next;

    assign en        = !skid_valid_reg;
    assign pix_stall = skid_valid_reg;

    s2lab_xyz u_xyz (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .pix       (pix),
        .out_valid (xyz_valid),
        .xyz       (xyz)
    );

    s2lab_cbrt u_cbrt_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xyz_valid),
        .t         (xyz.x),
        .out_valid (fx_valid),
        .res       (fx)
    );

    s2lab_cbrt u_cbrt_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xyz_valid),
        .t         (xyz.y),
        .out_valid (fy_valid),
        .res       (fy)
    );

    s2lab_cbrt u_cbrt_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xyz_valid),
        .t         (xyz.z),
        .out_valid (fz_valid),
        .res       (fz)
    );

    s2lab_lab u_lab (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fx_valid && fy_valid && fz_valid),
        .fx        (fx),
        .fy        (fy),
        .fz        (fz),
        .out_valid (pipe_valid),
        .lab       (pipe_lab)
    );

    always_comb
    begin
        lab_valid_next  = lab_valid_reg;
        lab_next        = lab_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!lab_valid_reg || !lab_stall) begin
            if (skid_valid_reg) begin
                lab_valid_next  = 1'b1;
                lab_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                lab_valid_next  = pipe_valid;
                lab_next        = pipe_lab;
            end
        end else if (en && pipe_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = pipe_lab;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lab_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            lab_valid_reg  <= lab_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lab_reg  <= lab_next;
        skid_reg <= skid_next;
    end

    assign lab_valid = lab_valid_reg;
    assign lab       = lab_reg;

    `ASSERT_IMPLY(skid_needs_out, skid_valid_reg, lab_valid_reg, "skid full with output empty")
    `ASSERT_NEXT(skid_catches, lab_valid_reg && lab_stall && pipe_valid && !skid_valid_reg, skid_valid_reg, "word lost at stalled output")

endmodule
